// ===== src/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int Window     = 32;
  localparam int SlotW      = $clog2(Window);
  localparam int CntW       = $clog2(Window + 1);
  localparam int TimerW     = 24;
  localparam int WinW       = 6;
  localparam int SeqW       = 32;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 24;

  localparam logic [CfgIdxW-1:0] REG_MAX_WINDOW = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT    = 1'd1;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [2:0] KIND_SENT    = 3'd0;
  localparam logic [2:0] KIND_LOST    = 3'd1;
  localparam logic [2:0] KIND_REFUSED = 3'd2;
  localparam logic [2:0] KIND_ACKED   = 3'd3;
  localparam logic [2:0] KIND_BAD_ACK = 3'd4;
  localparam logic [2:0] KIND_RETX    = 3'd5;

  localparam logic [WinW-1:0]   CWND_RESET    = WinW'(2);
  localparam logic [WinW-1:0]   MAXWIN_RESET  = WinW'(32);
  localparam logic [TimerW-1:0] TIMEOUT_RESET = TimerW'(300000);

  typedef struct packed {
    logic [1:0]      command;
    logic [SeqW-1:0] ack_number;
    logic            lost;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [SeqW-1:0] seq_number;
    logic [WinW-1:0] window_now;
    logic            last;
  } out_item_t;

endpackage

// ===== src/srsw_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// srsw_cmd_queue
// Two-entry queue between the command front end and the window engine.
// ----------------------------------------------------------------------------
module srsw_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  srsw_pkg::in_item_t wr_data,
  output logic               full,
  input  logic               rd,
  output srsw_pkg::in_item_t rd_data,
  output logic               empty
);
  import srsw_pkg::*;

  in_item_t   mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count overflow");
  a_pop_changes: assert property (@(posedge clk) disable iff (rst)
    (rd && !empty && !(wr && !full)) |=> count == $past(count) - 2'd1)
    else $error("queue count not reduced on read");
endmodule

// ===== src/srsw_engine.sv =====
// ----------------------------------------------------------------------------
// srsw_engine
// Window engine: runs one command at a time and pushes results out; slides the
// base one slot per cycle; scans slot timers one per cycle unless output stalls.
// ----------------------------------------------------------------------------
module srsw_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  srsw_pkg::in_item_t         cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_take,
  input  logic [srsw_pkg::WinW-1:0]  max_window,
  input  logic [srsw_pkg::TimerW-1:0] timeout_ticks,
  output srsw_pkg::out_item_t        res,
  output logic                       empty,
  input  logic                       pop
);
  import srsw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EMIT  = 3'd1;
  localparam logic [2:0] ST_SLIDE = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]        state;
  logic [SeqW-1:0]   base_seq, next_seq;
  logic [WinW-1:0]   cong_window;
  logic [SlotW-1:0]  head_slot;
  logic [Window-1:0] slot_acked, slot_running;
  logic [TimerW-1:0] slot_timer [Window];

  // pending result for a command, and the scan cursor
  out_item_t         pend;
  logic [CntW-1:0]   scan_i, scan_n;
  logic              have_hold;
  out_item_t         hold;

  // output register
  logic              out_full;
  out_item_t         out_reg;
  logic              out_load;

  assign res   = out_reg;
  assign empty = !out_full;
  wire out_free = !out_full || pop;

  logic [SeqW-1:0]  in_flight;
  logic [SeqW-1:0]  ack_off;
  logic [SlotW-1:0] send_slot, ack_slot, scan_slot;
  logic [WinW-1:0]  grow_limit;
  logic [TimerW-1:0] cur_timer;

  assign in_flight  = next_seq - base_seq;
  assign ack_off    = cmd.ack_number - base_seq;
  assign send_slot  = head_slot + in_flight[SlotW-1:0];
  assign ack_slot   = head_slot + ack_off[SlotW-1:0];
  assign scan_slot  = head_slot + scan_i[SlotW-1:0];
  assign grow_limit = (max_window < WinW'(Window)) ? max_window : WinW'(Window);
  assign cur_timer  = slot_timer[scan_slot];

  assign cmd_take = (state == ST_IDLE) && cmd_valid;

  // result register loads from emit, or from a held retransmit during the scan
  assign out_load = ((state == ST_EMIT) && out_free) ||
                    ((state == ST_SCAN) && (scan_i != scan_n) && slot_running[scan_slot] &&
                     (cur_timer <= TimerW'(1)) && have_hold && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_seq     <= '0;
      next_seq     <= '0;
      cong_window  <= CWND_RESET;
      head_slot    <= '0;
      slot_acked   <= '0;
      slot_running <= '0;
      out_full     <= 1'b0;
      have_hold    <= 1'b0;
      scan_i       <= '0;
      scan_n       <= '0;
    end else begin
      if (out_load) out_full <= 1'b1;
      else if (pop) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.command)
              CMD_SEND: begin
                pend.last <= 1'b1;
                if (in_flight >= SeqW'(cong_window) || in_flight >= SeqW'(Window)) begin
                  pend.kind       <= KIND_REFUSED;
                  pend.seq_number <= next_seq;
                  pend.window_now <= cong_window;
                end else begin
                  pend.kind       <= cmd.lost ? KIND_LOST : KIND_SENT;
                  pend.seq_number <= next_seq;
                  if (cmd.lost && cong_window > WinW'(2)) begin
                    cong_window     <= cong_window >> 1;
                    pend.window_now <= cong_window >> 1;
                  end else if (cmd.lost && cong_window < WinW'(2)) begin
                    cong_window     <= WinW'(2);
                    pend.window_now <= WinW'(2);
                  end else begin
                    pend.window_now <= cong_window;
                  end
                  slot_acked[send_slot]   <= 1'b0;
                  slot_running[send_slot] <= 1'b1;
                  slot_timer[send_slot]   <= timeout_ticks;
                  next_seq <= next_seq + 1'b1;
                end
                state <= ST_EMIT;
              end
              CMD_ACK: begin
                pend.last       <= 1'b1;
                pend.seq_number <= cmd.ack_number;
                if (ack_off >= in_flight || slot_acked[ack_slot]) begin
                  pend.kind       <= KIND_BAD_ACK;
                  pend.window_now <= cong_window;
                  state           <= ST_EMIT;
                end else begin
                  pend.kind <= KIND_ACKED;
                  if (cong_window < grow_limit && cong_window < 6'd63) begin
                    cong_window     <= cong_window + 1'b1;
                    pend.window_now <= cong_window + 1'b1;
                  end else begin
                    pend.window_now <= cong_window;
                  end
                  slot_acked[ack_slot]   <= 1'b1;
                  slot_running[ack_slot] <= 1'b0;
                  state                  <= ST_SLIDE;
                end
              end
              CMD_TICK: begin
                scan_i    <= '0;
                scan_n    <= (in_flight >= SeqW'(Window)) ? CntW'(Window)
                                                         : in_flight[CntW-1:0];
                have_hold <= 1'b0;
                state     <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SLIDE: begin
          // one head slot per cycle
          if (base_seq != next_seq && slot_acked[head_slot]) begin
            slot_acked[head_slot] <= 1'b0;
            base_seq  <= base_seq + 1'b1;
            head_slot <= head_slot + 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_reg  <= pend;
            state    <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          // one slot per cycle while no held expiry waits on the output; a found
          // expiry waits in hold until the next one (or the end) settles its last flag
          if (scan_i == scan_n) begin
            if (have_hold) begin
              pend  <= '{kind: hold.kind, seq_number: hold.seq_number,
                         window_now: hold.window_now, last: 1'b1};
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end else if (!slot_running[scan_slot]) begin
            scan_i <= scan_i + 1'b1;
          end else if (cur_timer > TimerW'(1)) begin
            slot_timer[scan_slot] <= cur_timer - 1'b1;
            scan_i <= scan_i + 1'b1;
          end else if (!have_hold || out_free) begin
            if (have_hold) begin
              out_reg  <= hold;
            end
            slot_timer[scan_slot] <= timeout_ticks;
            hold.kind       <= KIND_RETX;
            hold.seq_number <= base_seq + SeqW'(scan_i);
            hold.window_now <= cong_window;
            hold.last       <= 1'b0;
            have_hold       <= 1'b1;
            scan_i          <= scan_i + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_inflight: assert property (@(posedge clk) disable iff (rst)
    in_flight <= SeqW'(Window)) else $error("too many packets in flight");
  a_cwnd_range: assert property (@(posedge clk) disable iff (rst)
    cong_window != '0 && cong_window <= WinW'(Window))
    else $error("congestion window out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_full && !pop) |=> out_full && $stable(out_reg))
    else $error("waiting result changed before transfer");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state != ST_IDLE || $past(cmd.command) == CMD_NOP)
    else $error("command taken without work");
endmodule

// ===== src/selective_repeat_sender_window.sv =====
// Path: a command is written into the two-entry queue, taken by the engine in
// its idle state and put on the result ports from the emit state; a good ack
// first slides the window over each acked head slot.
// One command at a time: a tick scans each in-flight slot (up to 32) and may
// retransmit; a waiting result stalls the engine.
// Reset (rst, synchronous): window empty, congestion window 2, max_window 32.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Selective-repeat ARQ sender with congestion window, queue-style ports.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  srsw_pkg::in_item_t             in_item,
  output logic                           empty,
  input  logic                           pop,
  output srsw_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [srsw_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [srsw_pkg::CfgDataW-1:0]  cfg_data
);
  import srsw_pkg::*;

  logic [WinW-1:0]   max_window;
  logic [TimerW-1:0] timeout_ticks;
  in_item_t          q_data;
  logic              q_empty, q_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_window    <= MAXWIN_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_WINDOW: max_window    <= cfg_data[WinW-1:0];
        REG_TIMEOUT:    timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  srsw_cmd_queue u_queue (
    .clk(clk), .rst(rst), .wr(push), .wr_data(in_item), .full(full),
    .rd(q_take), .rd_data(q_data), .empty(q_empty)
  );

  srsw_engine u_engine (
    .clk(clk), .rst(rst), .cmd(q_data), .cmd_valid(!q_empty), .cmd_take(q_take),
    .max_window(max_window), .timeout_ticks(timeout_ticks),
    .res(out_item), .empty(empty), .pop(pop)
  );
endmodule
